// ===== rtl/smap_pkg.sv =====
// ----------------------------------------------------------------------------
// smap_pkg
// types, codes and sizes shared by the sorted alphabet symbol mapper
// ----------------------------------------------------------------------------
package smap_pkg;

  localparam int ALPHABET_MAX = 64;
  localparam int IDX_W        = $clog2(ALPHABET_MAX + 1);
  localparam int CP_W         = 21;
  localparam int OUT_IDX_W    = 7;

  localparam logic [CP_W-1:0] SPACE_POINT = CP_W'(32'h20);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MAP   = 2'd1,
    CMD_END   = 2'd2,
    CMD_CLEAR = 2'd3
  } smap_cmd_t;

  typedef enum logic [1:0] {
    ST_PRESENT = 2'd0,
    ST_ADDED   = 2'd1,
    ST_FULL    = 2'd2,
    ST_TERM    = 2'd3
  } smap_status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } smap_state_t;

  typedef struct packed {
    smap_cmd_t       command;
    logic [CP_W-1:0] code_point;
  } smap_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] symbol_index;
    smap_status_t         status;
    logic [OUT_IDX_W-1:0] space_index;
    logic [OUT_IDX_W-1:0] symbol_total;
  } smap_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            clr;
    logic [CP_W-1:0] cp;
  } smap_ctrl_t;

  // handed from one cell to its right neighbor
  typedef struct packed {
    logic            valid;
    logic            lt;
    logic [CP_W-1:0] value;
  } smap_link_t;

endpackage

// ===== rtl/smap_cell.sv =====
// ----------------------------------------------------------------------------
// smap_cell
// one alphabet entry: compares against the broadcast point, takes the point
// or its left neighbor's entry on insert
// ----------------------------------------------------------------------------
module smap_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smap_pkg::smap_ctrl_t         ctrl,
  input  logic [smap_pkg::CP_W-1:0]    home_value,
  input  logic                         home_valid,
  input  smap_pkg::smap_link_t         left,
  output smap_pkg::smap_link_t         right,
  output logic                         eq
);

  logic [smap_pkg::CP_W-1:0] value_r, value_nxt;
  logic                      valid_r, valid_nxt;
  logic                      lt;

  assign lt          = valid_r && (value_r < ctrl.cp);
  assign eq          = valid_r && (value_r == ctrl.cp);
  assign right.valid = valid_r;
  assign right.lt    = lt;
  assign right.value = value_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.ins) begin
      if (left.lt && !lt) begin
        value_nxt = ctrl.cp;
        valid_nxt = 1'b1;
      end else if (!left.lt) begin
        value_nxt = left.value;
        valid_nxt = left.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      value_r <= home_value;
      valid_r <= home_valid;
    end else begin
      value_r <= value_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== rtl/sorted_alphabet_symbol_mapper.sv =====
// ----------------------------------------------------------------------------
// sorted_alphabet_symbol_mapper
// sorted alphabet of code points held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy low. Busy is then high
// in the execute state while every cell compares its entry with the code
// point and, when an add inserts a new point, the row shifts right from the
// sorted slot. The result, if any, appears on out_data with out_strobe for
// exactly one cycle after that; the receiver cannot stall it, and a new
// word may be started in that same cycle. A clear word restores the reset
// alphabet in its execute cycle, with no sweep.
module sorted_alphabet_symbol_mapper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  smap_pkg::smap_in_t   in_data,
  output logic                 out_strobe,
  output smap_pkg::smap_out_t  out_data
);

  localparam int N = smap_pkg::ALPHABET_MAX;
  localparam int W = smap_pkg::IDX_W;

  smap_pkg::smap_state_t state_r, state_nxt;
  smap_pkg::smap_in_t    op_r;
  smap_pkg::smap_ctrl_t  ctrl;
  smap_pkg::smap_link_t  link [N+1];
  logic [N-1:0]          eq;

  logic [W-1:0] count_r, count_nxt;
  logic [W-1:0] space_r, space_nxt;
  logic         lws_r, lws_nxt;
  logic         exec;

  logic                 out_strobe_r, out_strobe_nxt;
  smap_pkg::smap_out_t  out_data_r, out_data_nxt;

  logic [W-1:0] match_pos;
  logic [W-1:0] slot_pos;
  logic         found;
  logic         full;
  logic         is_space;

  assign link[0].valid = 1'b1;
  assign link[0].lt    = 1'b1;
  assign link[0].value = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    smap_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .home_value ((g == 0) ? smap_pkg::SPACE_POINT : '0),
      .home_valid ((g == 0)),
      .left       (link[g]),
      .right      (link[g+1]),
      .eq         (eq[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smap_pkg::S_IDLE: if (start) state_nxt = smap_pkg::S_EXEC;
      smap_pkg::S_EXEC: state_nxt = smap_pkg::S_IDLE;
      default:          state_nxt = smap_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state_r)
      smap_pkg::S_IDLE: busy = 1'b0;
      smap_pkg::S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default:          busy = 1'b0;
    endcase
  end

  // position encoders
  always_comb begin
    match_pos = '0;
    slot_pos  = '0;
    for (int i = 0; i < N; i++) begin
      if (eq[i]) match_pos = match_pos | W'(i + 1);
      if (link[i].lt && !link[i+1].lt) slot_pos = slot_pos | W'(i + 1);
    end
  end

  assign found    = |eq;
  assign full     = (count_r >= W'(N));
  assign is_space = (op_r.code_point == smap_pkg::SPACE_POINT);

  always_comb begin
    ctrl.ins       = 1'b0;
    ctrl.clr       = 1'b0;
    ctrl.cp        = op_r.code_point;
    count_nxt      = count_r;
    space_nxt      = space_r;
    lws_nxt        = lws_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (exec) begin
      case (op_r.command)
        smap_pkg::CMD_ADD: begin
          out_strobe_nxt = 1'b1;
          if (found) begin
            out_data_nxt.symbol_index = smap_pkg::OUT_IDX_W'(match_pos);
            out_data_nxt.status       = smap_pkg::ST_PRESENT;
          end else if (full) begin
            out_data_nxt.symbol_index = '0;
            out_data_nxt.status       = smap_pkg::ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + W'(1);
            space_nxt = space_r + W'(op_r.code_point < smap_pkg::SPACE_POINT);
            out_data_nxt.symbol_index = smap_pkg::OUT_IDX_W'(slot_pos);
            out_data_nxt.status       = smap_pkg::ST_ADDED;
          end
        end
        smap_pkg::CMD_MAP: begin
          if (found && !(is_space && lws_r)) begin
            lws_nxt        = is_space;
            out_strobe_nxt = 1'b1;
            out_data_nxt.symbol_index = smap_pkg::OUT_IDX_W'(match_pos);
            out_data_nxt.status       = smap_pkg::ST_PRESENT;
          end
        end
        smap_pkg::CMD_END: begin
          lws_nxt        = 1'b0;
          out_strobe_nxt = 1'b1;
          out_data_nxt.symbol_index = '0;
          out_data_nxt.status       = smap_pkg::ST_TERM;
        end
        smap_pkg::CMD_CLEAR: begin
          ctrl.clr  = 1'b1;
          count_nxt = W'(1);
          space_nxt = W'(1);
          lws_nxt   = 1'b0;
        end
        default: out_strobe_nxt = 1'b0;
      endcase
      out_data_nxt.space_index  = smap_pkg::OUT_IDX_W'(space_nxt);
      out_data_nxt.symbol_total = smap_pkg::OUT_IDX_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= smap_pkg::S_IDLE;
      count_r      <= W'(1);
      space_r      <= W'(1);
      lws_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      space_r      <= space_nxt;
      lws_r        <= lws_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) op_r <= in_data;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== tb/smap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smap_checker
// Watches the word and result channels of the sorted alphabet symbol mapper.
// Each accepted word is run through a local model of the sorted alphabet.
// Any result it predicts is queued, and each strobed result is checked
// field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module smap_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  smap_pkg::smap_in_t  in_data,
  input  logic                out_strobe,
  input  smap_pkg::smap_out_t out_data,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen,
  output int                  full_seen
);

  logic [smap_pkg::CP_W-1:0] alphabet [smap_pkg::ALPHABET_MAX];
  int                        alpha_count;
  int                        space_pos;
  bit                        after_space;
  smap_pkg::smap_out_t       pending_results [$];
  int                        err_count;
  int                        res_count;
  int                        full_count;

  initial begin
    err_count  = 0;
    res_count  = 0;
    full_count = 0;
  end

  task automatic reset_alphabet();
    for (int i = 0; i < smap_pkg::ALPHABET_MAX; i++) alphabet[i] = '0;
    alphabet[0] = smap_pkg::SPACE_POINT;
    alpha_count = 1;
    space_pos   = 1;
    after_space = 1'b0;
  endtask

  function automatic int locate(logic [smap_pkg::CP_W-1:0] cp);
    for (int i = 0; i < alpha_count && i < smap_pkg::ALPHABET_MAX; i++) begin
      if (alphabet[i] == cp) return i + 1;
    end
    return 0;
  endfunction

  function automatic int rank_below(logic [smap_pkg::CP_W-1:0] cp);
    int n;
    n = 0;
    for (int i = 0; i < alpha_count && i < smap_pkg::ALPHABET_MAX; i++) begin
      if (alphabet[i] < cp) n++;
    end
    return n;
  endfunction

  function automatic smap_pkg::smap_out_t make_result(int idx, smap_pkg::smap_status_t st);
    smap_pkg::smap_out_t r;
    r.symbol_index = smap_pkg::OUT_IDX_W'(idx);
    r.status       = st;
    r.space_index  = smap_pkg::OUT_IDX_W'(space_pos);
    r.symbol_total = smap_pkg::OUT_IDX_W'(alpha_count);
    return r;
  endfunction

  task automatic update_alphabet(input smap_pkg::smap_in_t w, output bit emits,
                                 output smap_pkg::smap_out_t r);
    int                        pos;
    int                        slot;
    logic [smap_pkg::CP_W-1:0] cp;
    cp    = w.code_point;
    emits = 1'b0;
    r     = '0;
    case (w.command)
      smap_pkg::CMD_ADD: begin
        pos   = locate(cp);
        emits = 1'b1;
        if (pos != 0) begin
          r = make_result(pos, smap_pkg::ST_PRESENT);
        end else if (alpha_count >= smap_pkg::ALPHABET_MAX) begin
          r = make_result(0, smap_pkg::ST_FULL);
        end else begin
          slot = rank_below(cp);
          for (int i = alpha_count; i > slot; i--) alphabet[i] = alphabet[i-1];
          alphabet[slot] = cp;
          alpha_count++;
          space_pos = rank_below(smap_pkg::SPACE_POINT) + 1;
          r = make_result(slot + 1, smap_pkg::ST_ADDED);
        end
      end
      smap_pkg::CMD_MAP: begin
        pos = locate(cp);
        if (pos != 0) begin
          if (cp == smap_pkg::SPACE_POINT) begin
            if (!after_space) begin
              after_space = 1'b1;
              emits       = 1'b1;
            end
          end else begin
            after_space = 1'b0;
            emits       = 1'b1;
          end
          if (emits) r = make_result(pos, smap_pkg::ST_PRESENT);
        end
      end
      smap_pkg::CMD_END: begin
        after_space = 1'b0;
        emits       = 1'b1;
        r           = make_result(0, smap_pkg::ST_TERM);
      end
      default: begin
        reset_alphabet();
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input smap_pkg::smap_out_t exp,
                                 input smap_pkg::smap_out_t act);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: expected idx=%0d st=%0d space=%0d total=%0d,",
               $realtime, what, exp.symbol_index, exp.status, exp.space_index,
               exp.symbol_total);
      $display("    got idx=%0d st=%0d space=%0d total=%0d",
               act.symbol_index, act.status, act.space_index, act.symbol_total);
    end
  endtask

  always @(posedge clk) begin
    bit                  emits;
    smap_pkg::smap_out_t predicted;
    smap_pkg::smap_out_t oldest;
    if (!rst_n) begin
      reset_alphabet();
      pending_results.delete();
    end else begin
      if (out_strobe) begin
        res_count++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data);
        end else begin
          oldest = pending_results.pop_front();
          if (oldest.status == smap_pkg::ST_FULL) full_count++;
          if (out_data.symbol_index !== oldest.symbol_index ||
              out_data.status       !== oldest.status       ||
              out_data.space_index  !== oldest.space_index  ||
              out_data.symbol_total !== oldest.symbol_total) begin
            report_mismatch("result mismatch", oldest, out_data);
          end
        end
      end
      if (start && !busy) begin
        update_alphabet(in_data, emits, predicted);
        if (emits) pending_results.push_back(predicted);
      end
    end
    pending      <= pending_results.size();
    mismatches   <= err_count;
    results_seen <= res_count;
    full_seen    <= full_count;
  end

endmodule

// ===== tb/sorted_alphabet_symbol_mapper_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_alphabet_symbol_mapper_test
// Drives the sorted alphabet symbol mapper with a short directed sequence.
// That covers inserts below and above every entry, duplicates, space
// suppression, unknown points, end of word and clear. It is followed by
// random epochs of words drawn mostly from a per-epoch pool. Some pools are large
// enough to fill the table. The checker beside the block predicts and
// compares each result.
// ----------------------------------------------------------------------------
module sorted_alphabet_symbol_mapper_test;

  localparam int RANDOM_WORDS = 1950;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  smap_pkg::smap_in_t  in_data;
  logic                out_strobe;
  smap_pkg::smap_out_t out_data;

  int mismatches;
  int pending;
  int results_seen;
  int full_seen;

  int                        words_sent;
  int                        cycle_count;
  bit                        idle_on;
  bit                        big_epoch;
  int                        epoch_left;
  int                        pool_n;
  logic [smap_pkg::CP_W-1:0] pool [100];

  sorted_alphabet_symbol_mapper u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  smap_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_strobe   (out_strobe),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic smap_pkg::smap_in_t make_word(smap_pkg::smap_cmd_t c,
                                                   logic [smap_pkg::CP_W-1:0] cp);
    smap_pkg::smap_in_t w;
    w.command    = c;
    w.code_point = cp;
    return w;
  endfunction

  function automatic logic [smap_pkg::CP_W-1:0] random_point();
    case ($urandom_range(2))
      0:       return smap_pkg::CP_W'($urandom_range(127));
      1:       return smap_pkg::CP_W'($urandom_range(32'h10FFFF));
      default: return smap_pkg::CP_W'($urandom);
    endcase
  endfunction

  task automatic new_pool();
    big_epoch  = ($urandom_range(4) == 0);
    pool_n     = big_epoch ? 100 : $urandom_range(3, 20);
    epoch_left = big_epoch ? 400 : $urandom_range(20, 120);
    pool[0]    = smap_pkg::SPACE_POINT;
    for (int i = 1; i < pool_n; i++) pool[i] = random_point();
  endtask

  function automatic smap_pkg::smap_in_t pick_word();
    int r;
    int add_pct;
    add_pct = big_epoch ? 50 : 25;
    r = $urandom_range(99);
    if (r < add_pct) begin
      return make_word(smap_pkg::CMD_ADD, pool[$urandom_range(pool_n - 1)]);
    end
    r = $urandom_range(99);
    if (r < 50) return make_word(smap_pkg::CMD_MAP, pool[$urandom_range(pool_n - 1)]);
    if (r < 70) return make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT);
    if (r < 85) return make_word(smap_pkg::CMD_END, random_point());
    if (r < 92) return make_word(smap_pkg::CMD_MAP, random_point());
    return make_word(smap_pkg::smap_cmd_t'($urandom_range(big_epoch ? 2 : 3)),
                     smap_pkg::CP_W'($urandom));
  endfunction

  task automatic send_word(input smap_pkg::smap_in_t w);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    words_sent = 0;
    idle_on    = 1'b1;
    big_epoch  = 1'b0;
    epoch_left = 0;
    pool_n     = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::CP_W'(32'h41)));
    send_word(make_word(smap_pkg::CMD_ADD, smap_pkg::CP_W'(32'h61)));
    send_word(make_word(smap_pkg::CMD_ADD, smap_pkg::CP_W'(32'h61)));
    send_word(make_word(smap_pkg::CMD_ADD, '0));
    send_word(make_word(smap_pkg::CMD_ADD, '1));
    send_word(make_word(smap_pkg::CMD_ADD, smap_pkg::CP_W'(32'h10FFFF)));
    send_word(make_word(smap_pkg::CMD_ADD, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::CP_W'(32'h61)));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::CP_W'(32'h7)));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_END, '1));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_ADD, smap_pkg::CP_W'(32'h1F)));
    send_word(make_word(smap_pkg::CMD_MAP, '1));
    send_word(make_word(smap_pkg::CMD_CLEAR, '1));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::CP_W'(32'h61)));
    send_word(make_word(smap_pkg::CMD_MAP, smap_pkg::SPACE_POINT));
    send_word(make_word(smap_pkg::CMD_END, '0));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_on = !(n >= 700 && n < 1000);
      if (n == 500 || n == 1300) drain();
      if (epoch_left == 0) begin
        new_pool();
        send_word(make_word(smap_pkg::CMD_CLEAR, random_point()));
      end
      epoch_left--;
      send_word(pick_word());
    end

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d words in %0d cycles, %0d results checked",
             words_sent, cycle_count, results_seen);
    $display("table-full responses seen: %0d, mismatches: %0d", full_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/smap_pkg.sv
rtl/smap_cell.sv
rtl/sorted_alphabet_symbol_mapper.sv
tb/smap_checker.sv
tb/sorted_alphabet_symbol_mapper_test.sv
